[hw/rtl/sdh_pkg.sv]
// shared types and constants for the sd spi card host
`timescale 1ns / 1ps
`default_nettype none
package sdh_pkg;
   localparam int POLL_LIMIT     = 100;
   localparam int PREAMBLE_BYTES = 10;
   localparam int MAX_BLOCK      = 512;

   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_HOST  = 3'd3;
   localparam logic [2:0] OP_CARD  = 3'd4;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_BAD_R1 = 3'd1;
   localparam logic [2:0] ST_VCHECK = 3'd2;
   localparam logic [2:0] ST_TOKEN  = 3'd3;
   localparam logic [2:0] ST_REJECT = 3'd4;

   localparam logic [4:0] PH_IDLE = 5'd0, PH_PRE = 5'd1, PH_CMD = 5'd2, PH_POLL = 5'd3,
      PH_RET = 5'd4, PH_TOKEN = 5'd5, PH_CSD = 5'd6, PH_CSDCRC = 5'd7, PH_RDATA = 5'd8,
      PH_RCRC = 5'd9, PH_RBUSY = 5'd10, PH_WGAP = 5'd11, PH_WTOKEN = 5'd12,
      PH_WNEED = 5'd13, PH_WDATA = 5'd14, PH_WCRC = 5'd15, PH_WRESP = 5'd16,
      PH_WBUSY = 5'd17;

   localparam logic [5:0] CMD0 = 6'd0, CMD1 = 6'd1, CMD8 = 6'd8, CMD9 = 6'd9,
      CMD16 = 6'd16, CMD17 = 6'd17, CMD24 = 6'd24, CMD41 = 6'd41, CMD55 = 6'd55,
      CMD58 = 6'd58;

   localparam logic [0:0] REG_BLOCK_LENGTH = 1'd0;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] block_address;
      logic [9:0]  window_offset;
      logic [9:0]  window_length;
      logic [7:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        select_card;
      logic        need_data;
      logic        rx_valid;
      logic [7:0]  rx_byte;
      logic        done_res;
      logic [2:0]  status;
      logic        card_v2;
      logic        block_addressing;
      logic [41:0] card_bytes;
   } rsp_type;
endpackage
`default_nettype wire

[hw/rtl/sdh_core.sv]
// protocol engine: one byte transfer per step, state update and result forming
`timescale 1ns / 1ps
`default_nettype none
module sdh_core import sdh_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire req_type    req,
   input  wire logic [9:0] block_length,
   output rsp_type         rsp
);
   logic [4:0]  phase_ff, phase_in;
   logic [9:0]  count_ff, count_in;
   logic [6:0]  poll_ff, poll_in;
   logic [5:0]  cmd_ff, cmd_in;
   logic [31:0] word_ff, word_in;
   logic [7:0]  csd_ff [16];
   logic [9:0]  wstart_ff, wstart_in, wsize_ff, wsize_in;
   logic [41:0] cap_ff, cap_in;
   logic        v2_ff, v2_in, bmode_ff, bmode_in, sel_ff, sel_in;
   logic [7:0]  resp_ff, resp_in;
   logic [31:0] arg_ff, arg_in;
   logic        csd_we;
   logic [9:0]  eff_len;
   logic        txv, need, rxv, done;
   logic [7:0]  tx, rx;
   logic [2:0]  st;
   logic [7:0]  b;
   logic [4:0]  shamt;
   logic [21:0] cs2;
   logic [12:0] cs1;

   assign eff_len = (block_length > 10'(MAX_BLOCK)) ? 10'(MAX_BLOCK) : block_length;
   assign b = req.byte_value;

   function automatic logic in_win(input logic [9:0] i, input logic [9:0] s,
                                   input logic [9:0] n);
      logic [9:0] d;
      d = i - s;
      return (i >= s) && (d < n);
   endfunction

   function automatic logic [7:0] frame(input logic [9:0] k, input logic [5:0] c,
                                        input logic [31:0] a);
      logic [7:0] r;
      r = 8'h01;
      if (k < 10'd2) r = 8'hFF;
      else if (k == 10'd2) r = 8'h40 | {2'b00, c};
      else if (k == 10'd3) r = a[31:24];
      else if (k == 10'd4) r = a[23:16];
      else if (k == 10'd5) r = a[15:8];
      else if (k == 10'd6) r = a[7:0];
      else if (c == CMD8) r = 8'h87;
      else if (c == CMD0) r = 8'h95;
      return r;
   endfunction

   // capacity from the csd store, both layouts
   always_comb begin
      cs2 = {csd_ff[7][5:0], csd_ff[8], csd_ff[9]};
      cs1 = {1'b0, csd_ff[6][1:0], csd_ff[7], csd_ff[8][7:6]};
      shamt = 5'(csd_ff[5][3:0]) + 5'(csd_ff[9][5:3]) + 5'd2;
   end

   // next state and result for one transfer
   always_comb begin
      phase_in = phase_ff; count_in = count_ff; poll_in = poll_ff; cmd_in = cmd_ff;
      word_in = word_ff; wstart_in = wstart_ff; wsize_in = wsize_ff; cap_in = cap_ff;
      v2_in = v2_ff; bmode_in = bmode_ff; sel_in = sel_ff; resp_in = resp_ff;
      arg_in = arg_ff; csd_we = 1'b0;
      txv = 1'b0; tx = 8'h00; need = 1'b0; rxv = 1'b0; rx = 8'h00; done = 1'b0;
      st = ST_OK;
      begin : work
         logic issue_en, fin, aft;
         logic [5:0] icmd;
         logic [31:0] iarg;
         logic [2:0] fst;
         logic [7:0] r1;
         logic nw;
         logic [9:0] nc;
         issue_en = 1'b0; fin = 1'b0; aft = 1'b0; icmd = CMD0; iarg = '0;
         fst = ST_OK; r1 = resp_ff; nw = 1'b0; nc = count_ff;
         case (req.opcode)
            OP_INIT: begin
               sel_in = 1'b0; phase_in = PH_PRE; count_in = '0; txv = 1'b1; tx = 8'hFF;
            end
            OP_READ, OP_WRITE: begin
               wstart_in = req.window_offset; wsize_in = req.window_length; sel_in = 1'b1;
               issue_en = 1'b1; icmd = (req.opcode == OP_READ) ? CMD17 : CMD24;
               iarg = req.block_address;
            end
            OP_HOST: begin
               if (phase_ff == PH_WNEED) begin
                  phase_in = PH_WDATA; txv = 1'b1; tx = b;
               end
            end
            OP_CARD: begin
               case (phase_ff)
                  PH_PRE: begin
                     count_in = count_ff + 10'd1;
                     if (count_in < 10'(PREAMBLE_BYTES)) begin
                        txv = 1'b1; tx = 8'hFF;
                     end else begin
                        sel_in = 1'b1; issue_en = 1'b1; icmd = CMD0; iarg = '0;
                     end
                  end
                  PH_CMD: begin
                     count_in = count_ff + 10'd1;
                     txv = 1'b1;
                     if (count_in < 10'd8) tx = frame(count_in, cmd_ff, arg_ff);
                     else begin
                        phase_in = PH_POLL; poll_in = '0; tx = 8'hFF;
                     end
                  end
                  PH_POLL: begin
                     if (b != 8'hFF) begin
                        resp_in = b; r1 = b;
                        if (cmd_ff == CMD8 || cmd_ff == CMD58) begin
                           phase_in = PH_RET; count_in = '0; txv = 1'b1; tx = 8'hFF;
                        end else aft = 1'b1;
                     end else begin
                        poll_in = poll_ff + 7'd1;
                        if (poll_in >= 7'(POLL_LIMIT)) begin
                           fin = 1'b1; fst = ST_BAD_R1;
                        end else begin
                           txv = 1'b1; tx = 8'hFF;
                        end
                     end
                  end
                  PH_RET: begin
                     word_in = {word_ff[23:0], b};
                     count_in = count_ff + 10'd1;
                     if (count_in < 10'd4) begin
                        txv = 1'b1; tx = 8'hFF;
                     end else aft = 1'b1;
                  end
                  PH_TOKEN: begin
                     if (b == 8'hFF) begin
                        txv = 1'b1; tx = 8'hFF;
                     end else if (!b[7]) begin
                        fin = 1'b1; fst = ST_TOKEN;
                     end else begin
                        count_in = '0;
                        if (cmd_ff == CMD9) phase_in = PH_CSD;
                        else phase_in = (eff_len == '0) ? PH_RCRC : PH_RDATA;
                        txv = 1'b1; tx = 8'hFF;
                     end
                  end
                  PH_CSD: begin
                     csd_we = 1'b1;
                     count_in = count_ff + 10'd1;
                     if (count_in >= 10'd16) begin
                        phase_in = PH_CSDCRC; count_in = '0;
                     end
                     txv = 1'b1; tx = 8'hFF;
                  end
                  PH_CSDCRC: begin
                     count_in = count_ff + 10'd1;
                     if (count_in < 10'd2) begin
                        txv = 1'b1; tx = 8'hFF;
                     end else begin
                        if (csd_ff[0][6]) cap_in = {1'b0, cs2 + 22'd0, 19'd0} + 42'h80000;
                        else cap_in = 42'({29'd0, cs1 + 13'd1} << shamt);
                        fin = 1'b1; fst = ST_OK;
                     end
                  end
                  PH_RDATA: begin
                     if (in_win(count_ff, wstart_ff, wsize_ff)) begin
                        rxv = 1'b1; rx = b;
                     end
                     count_in = count_ff + 10'd1;
                     if (count_in >= eff_len) begin
                        phase_in = PH_RCRC; count_in = '0;
                     end
                     txv = 1'b1; tx = 8'hFF;
                  end
                  PH_RCRC: begin
                     count_in = count_ff + 10'd1;
                     if (count_in >= 10'd2) phase_in = PH_RBUSY;
                     txv = 1'b1; tx = 8'hFF;
                  end
                  PH_RBUSY: begin
                     if (b == 8'hFF) begin
                        fin = 1'b1; fst = ST_OK;
                     end else begin
                        txv = 1'b1; tx = 8'hFF;
                     end
                  end
                  PH_WGAP: begin
                     phase_in = PH_WTOKEN; txv = 1'b1; tx = 8'hFE;
                  end
                  PH_WTOKEN: begin
                     nw = 1'b1; nc = '0;
                  end
                  PH_WDATA: begin
                     nw = 1'b1; nc = count_ff + 10'd1;
                  end
                  PH_WCRC: begin
                     count_in = count_ff + 10'd1;
                     txv = 1'b1;
                     if (count_in < 10'd2) tx = 8'h00;
                     else begin
                        phase_in = PH_WRESP; tx = 8'hFF;
                     end
                  end
                  PH_WRESP: begin
                     resp_in = b; phase_in = PH_WBUSY; txv = 1'b1; tx = 8'hFF;
                  end
                  PH_WBUSY: begin
                     if (b == 8'h00) begin
                        txv = 1'b1; tx = 8'hFF;
                     end else begin
                        fin = 1'b1;
                        fst = (resp_ff[4:0] == 5'h05) ? ST_OK : ST_REJECT;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         // next write byte decision
         if (nw) begin
            count_in = nc;
            if (nc >= eff_len) begin
               phase_in = PH_WCRC; count_in = '0; txv = 1'b1; tx = 8'h00;
            end else if (in_win(nc, wstart_ff, wsize_ff)) begin
               phase_in = PH_WNEED; need = 1'b1;
            end else begin
               phase_in = PH_WDATA; txv = 1'b1; tx = 8'h00;
            end
         end
         // command sequencing once r1 and any trailing word are in
         if (aft) begin
            case (cmd_ff)
               CMD0: begin
                  if (r1 != 8'h01) begin fin = 1'b1; fst = ST_BAD_R1; end
                  else begin issue_en = 1'b1; icmd = CMD8; iarg = 32'h1AA; end
               end
               CMD8: begin
                  if (r1[2]) begin
                     v2_in = 1'b0; bmode_in = 1'b0; issue_en = 1'b1; icmd = CMD1;
                  end else if (r1 == 8'h01) begin
                     v2_in = 1'b1;
                     if (word_in[11:0] != 12'h1AA) begin fin = 1'b1; fst = ST_VCHECK; end
                     else begin issue_en = 1'b1; icmd = CMD55; end
                  end else begin
                     fin = 1'b1; fst = ST_BAD_R1;
                  end
               end
               CMD1: begin issue_en = 1'b1; icmd = r1[0] ? CMD1 : CMD58; end
               CMD55: begin issue_en = 1'b1; icmd = CMD41; iarg = 32'h40000000; end
               CMD41: begin issue_en = 1'b1; icmd = r1[0] ? CMD55 : CMD58; end
               CMD58: begin
                  bmode_in = word_in[30]; issue_en = 1'b1; icmd = CMD16;
                  iarg = {22'd0, eff_len};
               end
               CMD16: begin
                  if (r1 != 8'h00) begin fin = 1'b1; fst = ST_BAD_R1; end
                  else begin issue_en = 1'b1; icmd = CMD9; end
               end
               CMD9: begin phase_in = PH_TOKEN; txv = 1'b1; tx = 8'hFF; end
               CMD17: begin
                  if (r1 != 8'h00) begin fin = 1'b1; fst = ST_BAD_R1; end
                  else begin phase_in = PH_TOKEN; txv = 1'b1; tx = 8'hFF; end
               end
               default: begin
                  if (r1 != 8'h00) begin fin = 1'b1; fst = ST_BAD_R1; end
                  else begin phase_in = PH_WGAP; txv = 1'b1; tx = 8'hFF; end
               end
            endcase
         end
         if (issue_en) begin
            cmd_in = icmd; arg_in = iarg; phase_in = PH_CMD; count_in = '0;
            txv = 1'b1; tx = 8'hFF;
         end
         if (fin) begin
            phase_in = PH_IDLE; sel_in = 1'b0; done = 1'b1; st = fst;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; count_ff <= '0; poll_ff <= '0; cmd_ff <= '0;
         word_ff <= '0; wstart_ff <= '0; wsize_ff <= '0; cap_ff <= '0;
         v2_ff <= 1'b0; bmode_ff <= 1'b0; sel_ff <= 1'b0; resp_ff <= '0; arg_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; count_ff <= count_in; poll_ff <= poll_in; cmd_ff <= cmd_in;
         word_ff <= word_in; wstart_ff <= wstart_in; wsize_ff <= wsize_in;
         cap_ff <= cap_in; v2_ff <= v2_in; bmode_ff <= bmode_in; sel_ff <= sel_in;
         resp_ff <= resp_in; arg_ff <= arg_in;
      end
   end

   // csd bytes as they arrive
   always_ff @(posedge clock) begin
      if (step && csd_we) csd_ff[count_ff[3:0]] <= b;
   end

   always_comb begin
      rsp.tx_valid = txv; rsp.tx_byte = tx; rsp.select_card = sel_in;
      rsp.need_data = need; rsp.rx_valid = rxv; rsp.rx_byte = rx;
      rsp.done_res = done; rsp.status = st; rsp.card_v2 = v2_in;
      rsp.block_addressing = bmode_in; rsp.card_bytes = cap_in;
   end

   a_poll_bound: assert property (@(posedge clock) disable iff (reset)
      poll_ff <= 7'(POLL_LIMIT)) else $error("poll count past limit");
   a_idle_desel: assert property (@(posedge clock) disable iff (reset)
      step && rsp.done_res |=> !sel_ff) else $error("card selected after finish");
   a_done_no_tx: assert property (@(posedge clock) disable iff (reset)
      step && rsp.done_res |-> !rsp.tx_valid) else $error("request on finish");
endmodule
`default_nettype wire

[hw/rtl/sd_spi_card_host.sv]
// top level of the sd spi card host: channels, register port, engine
// One byte transfer per item: each accepted item is registered, processed by the
// combinational engine and its result held in an output register, so a new item
// is taken every cycle unless a result waits stalled in the output register. The
// block_length register answers at addresses 0 to 3 (paddr bit 2 clear); write it
// only while no operation is running.
`timescale 1ns / 1ps
`default_nettype none
module sd_spi_card_host import sdh_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [31:0] req_block_address,
   input  wire logic [9:0]  req_window_offset,
   input  wire logic [9:0]  req_window_length,
   input  wire logic [7:0]  req_byte_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_select_card,
   output logic             rsp_need_data,
   output logic             rsp_rx_valid,
   output logic [7:0]       rsp_rx_byte,
   output logic             rsp_done_res,
   output logic [2:0]       rsp_status,
   output logic             rsp_card_v2,
   output logic             rsp_block_addressing,
   output logic [41:0]      rsp_card_bytes,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [9:0] blen_ff;
   logic       hv_ff, ov_ff;
   req_type    hold_ff;
   rsp_type    out_ff, eng;
   logic       step, out_free;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BLOCK_LENGTH) ? {22'd0, blen_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) blen_ff <= 10'd512;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_BLOCK_LENGTH)
         blen_ff <= csr_pwdata[9:0];
   end

   // input register feeds engine when result register is free
   assign out_free  = !ov_ff || !rsp_stall;
   assign step      = hv_ff && out_free;
   assign req_stall = hv_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         if (!req_stall) hv_ff <= req_valid;
         if (out_free) ov_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall)
         hold_ff <= '{req_opcode, req_block_address, req_window_offset,
                      req_window_length, req_byte_value};
      if (step) out_ff <= eng;
   end

   sdh_core u_core (.clock(clock), .reset(reset), .step(step), .req(hold_ff),
      .block_length(blen_ff), .rsp(eng));

   assign rsp_valid = ov_ff;
   assign rsp_tx_valid = out_ff.tx_valid;
   assign rsp_tx_byte = out_ff.tx_byte;
   assign rsp_select_card = out_ff.select_card;
   assign rsp_need_data = out_ff.need_data;
   assign rsp_rx_valid = out_ff.rx_valid;
   assign rsp_rx_byte = out_ff.rx_byte;
   assign rsp_done_res = out_ff.done_res;
   assign rsp_status = out_ff.status;
   assign rsp_card_v2 = out_ff.card_v2;
   assign rsp_block_addressing = out_ff.block_addressing;
   assign rsp_card_bytes = out_ff.card_bytes;

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      ov_ff && rsp_stall |=> ov_ff) else $error("result dropped");
   a_hold_step: assert property (@(posedge clock) disable iff (reset)
      hv_ff && !req_stall |-> step) else $error("held item not processed");
   a_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == ST_OK) else $error("stray status");
endmodule
`default_nettype wire
